/* rtl/lc3_instruction_execute_defines.svh */
// Assertion macros shared by the LC-3 execute block.
`ifndef LC3_INSTRUCTION_EXECUTE_DEFINES_SVH
`define LC3_INSTRUCTION_EXECUTE_DEFINES_SVH

`ifndef SYNTHESIS

// The condition must never hold while out of reset.
`define LC3_ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define LC3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define LC3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`else

`define LC3_ASSERT_NEVER(label, clk, rst_n, cond, msg)
`define LC3_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`define LC3_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)

`endif

`endif

/* rtl/lc3_pkg.sv */
// Types and constants of the LC-3 execute block.
`default_nettype none

package lc3_pkg;

    // Commands carried by an input beat.
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_START = 2'd1;
    localparam logic [1:0] CMD_EXEC  = 2'd2;

    // Condition codes.
    localparam logic [1:0] CC_NEG  = 2'd0;
    localparam logic [1:0] CC_ZERO = 2'd1;
    localparam logic [1:0] CC_POS  = 2'd2;

    // Opcodes.
    localparam logic [3:0] OP_BR   = 4'h0;
    localparam logic [3:0] OP_ADD  = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h2;
    localparam logic [3:0] OP_ST   = 4'h3;
    localparam logic [3:0] OP_JSR  = 4'h4;
    localparam logic [3:0] OP_AND  = 4'h5;
    localparam logic [3:0] OP_LDR  = 4'h6;
    localparam logic [3:0] OP_STR  = 4'h7;
    localparam logic [3:0] OP_NOT  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_STI  = 4'hB;
    localparam logic [3:0] OP_JMP  = 4'hC;
    localparam logic [3:0] OP_LEA  = 4'hE;
    localparam logic [3:0] OP_TRAP = 4'hF;

    // Trap vectors.
    localparam logic [7:0] VEC_GETC = 8'h20;
    localparam logic [7:0] VEC_OUT  = 8'h21;
    localparam logic [7:0] VEC_IN   = 8'h23;
    localparam logic [7:0] VEC_HALT = 8'h25;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] addr;
        logic [15:0] data;
        logic [7:0]  key_char;
    } t_in_item;

    typedef struct packed {
        logic [15:0] pc_now;
        logic [1:0]  cond_code;
        logic [7:0]  char_out;
        logic        char_valid;
        logic        halted;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FETCH,
        ST_REG,
        ST_MEM1,
        ST_MEM2
    } t_state;

endpackage

`default_nettype wire

/* rtl/lc3_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
`default_nettype none

module lc3_ram #(
    parameter int unsigned WIDTH = 16,
    parameter int unsigned DEPTH = 256,
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

/* rtl/lc3_instruction_execute.sv */
// Top level of the LC-3 core: command sequencer, register file and word memory.
`default_nettype none

`include "lc3_instruction_execute_defines.svh"

// LC-3 core over a MEM_WORDS x 16 word memory. Each input beat writes one program word,
// starts the program (PC from the start_pc register, R0-R7 cleared, CC set to zero,
// halt cleared) or executes one instruction; other commands and halted executes change
// nothing. Every beat gives exactly one result beat carrying the PC, CC, an optional
// character and the halt flag. Input beats land in a one-deep holding register, which
// is ready whenever it is empty or is being emptied in the same cycle, so the next beat
// is taken while the current one is still at work or its result still waits in the
// output register. Both memory and the register file are synchronous RAMs with a
// registered read, and the single memory read port sets the pace: writes and starts
// finish in the idle state, ALU, branch, jump, LEA, ST, STR and trap instructions pass
// through fetch issue, fetch return with register read and execute, LD, LDR and STI add
// one memory read and LDI two, and a step may wait for the output register to drain.
// Memory needs no clearing pass: a word that was never written reads back as whatever
// the RAM holds. Addresses at or above MEM_WORDS read as zero and ignore writes. The
// register file is cleared at reset and by a start through per-register valid bits.
module lc3_instruction_execute
    import lc3_pkg::*;
#(
    parameter int unsigned MEM_WORDS = 65536
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_ready,
    input  wire t_in_item  i_in,
    output logic           o_out_valid,
    input  wire logic      i_out_ready,
    output t_out_item      o_out,
    input  wire logic      i_cfg_valid,
    output logic           o_cfg_ready,
    input  wire logic [15:0] i_cfg_data
);

    localparam int unsigned AW = $clog2(MEM_WORDS);
    localparam logic [16:0] MEM_LIMIT = 17'(MEM_WORDS);

    // Address lies inside the implemented memory.
    function automatic logic in_mem(input logic [15:0] a);
        return {1'b0, a} < MEM_LIMIT;
    endfunction

    // Condition code of a value written to a register.
    function automatic logic [1:0] cc_of(input logic [15:0] v);
        if (v == 16'h0000) begin
            return CC_ZERO;
        end else if (v[15]) begin
            return CC_NEG;
        end else begin
            return CC_POS;
        end
    endfunction

    // Architectural and control registers.
    t_state      r_state, n_state;
    logic        r_pend_valid;
    t_in_item    r_pend;
    logic        r_out_valid;
    t_out_item   r_out;
    logic [15:0] r_pc, n_pc;
    logic [1:0]  r_cc, n_cc;
    logic        r_halt, n_halt;
    logic [15:0] r_start_pc;
    logic [7:0]  r_rf_vld;
    logic [15:0] r_ir;
    logic [15:0] r_ea, n_ea;
    logic [7:0]  r_key, n_key;
    logic        r_mem_oob;
    logic        r_rfa_vld, r_rfb_vld;

    // Sequencer decisions.
    logic        out_free;
    logic        pend_pop;
    logic        out_load;
    logic [7:0]  ch;
    logic        chv;

    // Memory port.
    logic          mem_we;
    logic [15:0]   mem_waddr16;
    logic [15:0]   mem_wdata;
    logic [15:0]   mem_raddr16;
    logic [15:0]   mem_rdata;
    logic [15:0]   mem_q;

    // Register file ports.
    logic          rf_we;
    logic [2:0]    rf_waddr;
    logic [15:0]   rf_wdata;
    logic          rf_clear;
    logic [2:0]    rfa_raddr, rfb_raddr;
    logic [15:0]   rfa_rdata, rfb_rdata;
    logic [15:0]   rfa_q, rfb_q;

    // Decode and datapath.
    logic [15:0] ir_cur;
    logic [3:0]  opcode;
    logic [15:0] op_b;
    logic [15:0] off6, off9, off11;
    logic [15:0] pc_off9, pc_off11, base_off6;
    logic        br_take;

    // The holding register takes a new beat in the same cycle as it hands its
    // current one to the sequencer, so commands can follow with no gap.
    assign o_in_ready  = !r_pend_valid || pend_pop;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;
    assign out_free    = !r_out_valid || i_out_ready;

    // The instruction word comes straight from memory in the fetch-return cycle and
    // from the instruction register afterwards, so register reads stay stable while
    // a commit waits for the output register.
    assign ir_cur = (r_state == ST_FETCH) ? mem_q : r_ir;
    assign opcode = ir_cur[15:12];

    // Port A reads SR1 or BaseR, or R0 for the traps. Port B reads SR2, or the
    // source register of a store.
    assign rfa_raddr = (opcode == OP_TRAP) ? 3'd0 : ir_cur[8:6];
    assign rfb_raddr = (opcode inside {OP_ST, OP_STI, OP_STR}) ? ir_cur[11:9] : ir_cur[2:0];

    // Read data masked by the registered valid bit and the out-of-range flag.
    assign rfa_q = r_rfa_vld ? rfa_rdata : 16'h0000;
    assign rfb_q = r_rfb_vld ? rfb_rdata : 16'h0000;
    assign mem_q = r_mem_oob ? 16'h0000 : mem_rdata;

    assign off6      = {{10{r_ir[5]}}, r_ir[5:0]};
    assign off9      = {{7{r_ir[8]}}, r_ir[8:0]};
    assign off11     = {{5{r_ir[10]}}, r_ir[10:0]};
    assign op_b      = r_ir[5] ? {{11{r_ir[4]}}, r_ir[4:0]} : rfb_q;
    assign pc_off9   = r_pc + off9;
    assign pc_off11  = r_pc + off11;
    assign base_off6 = rfa_q + off6;
    assign br_take   = (r_ir[11] && (r_cc == CC_NEG))  ||
                       (r_ir[10] && (r_cc == CC_ZERO)) ||
                       (r_ir[9]  && (r_cc == CC_POS));

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (pend_pop && (r_pend.cmd == CMD_EXEC) && !r_halt) begin
                    n_state = ST_FETCH;
                end
            end
            ST_FETCH: begin
                n_state = ST_REG;
            end
            ST_REG: begin
                if (opcode inside {OP_LD, OP_LDI, OP_LDR, OP_STI}) begin
                    n_state = ST_MEM1;
                end else if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MEM1: begin
                if (opcode == OP_LDI) begin
                    n_state = ST_MEM2;
                end else if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            ST_MEM2: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Datapath control and architectural updates. Every side effect of a
    // committing step is gated by out_load, so a step that waits for the output
    // register repeats harmlessly.
    always_comb begin
        n_pc        = r_pc;
        n_cc        = r_cc;
        n_halt      = r_halt;
        n_ea        = r_ea;
        n_key       = r_key;
        pend_pop    = 1'b0;
        out_load    = 1'b0;
        ch          = 8'h00;
        chv         = 1'b0;
        mem_we      = 1'b0;
        mem_waddr16 = 16'h0000;
        mem_wdata   = 16'h0000;
        mem_raddr16 = r_ea;
        rf_we       = 1'b0;
        rf_waddr    = 3'd0;
        rf_wdata    = 16'h0000;
        rf_clear    = 1'b0;

        case (r_state)
            ST_IDLE: begin
                if (r_pend_valid) begin
                    case (r_pend.cmd)
                        CMD_EXEC: begin
                            if (!r_halt) begin
                                // Issue the fetch; the counter advances at once.
                                pend_pop    = 1'b1;
                                mem_raddr16 = r_pc;
                                n_pc        = r_pc + 16'd1;
                                n_key       = r_pend.key_char;
                            end else if (out_free) begin
                                pend_pop = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                        CMD_WRITE: begin
                            if (out_free) begin
                                pend_pop    = 1'b1;
                                out_load    = 1'b1;
                                mem_we      = 1'b1;
                                mem_waddr16 = r_pend.addr;
                                mem_wdata   = r_pend.data;
                            end
                        end
                        CMD_START: begin
                            if (out_free) begin
                                pend_pop = 1'b1;
                                out_load = 1'b1;
                                n_pc     = r_start_pc;
                                n_cc     = CC_ZERO;
                                n_halt   = 1'b0;
                                rf_clear = 1'b1;
                            end
                        end
                        default: begin
                            if (out_free) begin
                                pend_pop = 1'b1;
                                out_load = 1'b1;
                            end
                        end
                    endcase
                end
            end

            ST_REG: begin
                case (opcode)
                    OP_LD, OP_LDI, OP_STI: begin
                        mem_raddr16 = pc_off9;
                        n_ea        = pc_off9;
                    end
                    OP_LDR: begin
                        mem_raddr16 = base_off6;
                        n_ea        = base_off6;
                    end
                    default: begin
                        if (out_free) begin
                            out_load = 1'b1;
                            case (opcode)
                                OP_ADD, OP_AND, OP_NOT, OP_LEA: begin
                                    rf_we    = 1'b1;
                                    rf_waddr = r_ir[11:9];
                                    case (opcode)
                                        OP_ADD:  rf_wdata = rfa_q + op_b;
                                        OP_AND:  rf_wdata = rfa_q & op_b;
                                        OP_NOT:  rf_wdata = ~rfa_q;
                                        default: rf_wdata = pc_off9;
                                    endcase
                                    n_cc = cc_of(rf_wdata);
                                end
                                OP_BR: begin
                                    if (br_take) begin
                                        n_pc = pc_off9;
                                    end
                                end
                                OP_JMP: begin
                                    n_pc = rfa_q;
                                end
                                OP_JSR: begin
                                    // Target is taken from the read before R7 changes.
                                    n_pc     = r_ir[11] ? pc_off11 : rfa_q;
                                    rf_we    = 1'b1;
                                    rf_waddr = 3'd7;
                                    rf_wdata = r_pc;
                                end
                                OP_ST: begin
                                    mem_we      = 1'b1;
                                    mem_waddr16 = pc_off9;
                                    mem_wdata   = rfb_q;
                                end
                                OP_STR: begin
                                    mem_we      = 1'b1;
                                    mem_waddr16 = base_off6;
                                    mem_wdata   = rfb_q;
                                end
                                OP_TRAP: begin
                                    case (r_ir[7:0])
                                        VEC_GETC: begin
                                            rf_we    = 1'b1;
                                            rf_waddr = 3'd0;
                                            rf_wdata = {8'h00, r_key};
                                        end
                                        VEC_OUT: begin
                                            ch  = rfa_q[7:0];
                                            chv = 1'b1;
                                        end
                                        VEC_IN: begin
                                            rf_we    = 1'b1;
                                            rf_waddr = 3'd0;
                                            rf_wdata = {8'h00, r_key};
                                            ch       = r_key;
                                            chv      = 1'b1;
                                        end
                                        VEC_HALT: begin
                                            n_halt = 1'b1;
                                        end
                                        default: begin
                                        end
                                    endcase
                                end
                                default: begin
                                end
                            endcase
                        end
                    end
                endcase
            end

            ST_MEM1: begin
                if (opcode == OP_LDI) begin
                    // The pointer word becomes the address of the second read.
                    mem_raddr16 = mem_q;
                    n_ea        = mem_q;
                end else if (out_free) begin
                    out_load = 1'b1;
                    if (opcode == OP_STI) begin
                        mem_we      = 1'b1;
                        mem_waddr16 = mem_q;
                        mem_wdata   = rfb_q;
                    end else begin
                        rf_we    = 1'b1;
                        rf_waddr = r_ir[11:9];
                        rf_wdata = mem_q;
                        n_cc     = cc_of(mem_q);
                    end
                end
            end

            ST_MEM2: begin
                if (out_free) begin
                    out_load = 1'b1;
                    rf_we    = 1'b1;
                    rf_waddr = r_ir[11:9];
                    rf_wdata = mem_q;
                    n_cc     = cc_of(mem_q);
                end
            end

            default: begin
            end
        endcase
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            r_pc         <= 16'h0000;
            r_cc         <= CC_ZERO;
            r_halt       <= 1'b0;
            r_start_pc   <= 16'h3000;
            r_rf_vld     <= 8'h00;
        end else begin
            r_state      <= n_state;
            r_pend_valid <= (r_pend_valid && !pend_pop) || (i_in_valid && o_in_ready);
            r_out_valid  <= out_load || (r_out_valid && !i_out_ready);
            r_pc         <= n_pc;
            r_cc         <= n_cc;
            r_halt       <= n_halt;
            if (i_cfg_valid && o_cfg_ready) begin
                r_start_pc <= i_cfg_data;
            end
            if (rf_clear) begin
                r_rf_vld <= 8'h00;
            end else if (rf_we) begin
                r_rf_vld[rf_waddr] <= 1'b1;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_pend <= i_in;
        end
        if (out_load) begin
            r_out.pc_now     <= n_pc;
            r_out.cond_code  <= n_cc;
            r_out.char_out   <= ch;
            r_out.char_valid <= chv;
            r_out.halted     <= n_halt;
        end
        if (r_state == ST_FETCH) begin
            r_ir <= mem_q;
        end
        r_ea      <= n_ea;
        r_key     <= n_key;
        r_mem_oob <= !in_mem(mem_raddr16);
        r_rfa_vld <= r_rf_vld[rfa_raddr];
        r_rfb_vld <= r_rf_vld[rfb_raddr];
    end

    lc3_ram #(
        .WIDTH (16),
        .DEPTH (MEM_WORDS)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we && in_mem(mem_waddr16)),
        .i_waddr (mem_waddr16[AW-1:0]),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr16[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // Two copies of the register file give two read ports; both take every write.
    lc3_ram #(
        .WIDTH (16),
        .DEPTH (8)
    ) u_rf_a (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rfa_raddr),
        .o_rdata (rfa_rdata)
    );

    lc3_ram #(
        .WIDTH (16),
        .DEPTH (8)
    ) u_rf_b (
        .i_clk   (i_clk),
        .i_we    (rf_we),
        .i_waddr (rf_waddr),
        .i_wdata (rf_wdata),
        .i_raddr (rfb_raddr),
        .o_rdata (rfb_rdata)
    );

    // A result is only ever written into a free output register.
    `LC3_ASSERT_IMPLY(a_out_no_overwrite, i_clk, i_rst_n, out_load, out_free, "beat overwritten")

    // Register file and memory writes are always the last step of an item.
    `LC3_ASSERT_NEXT(a_write_is_last, i_clk, i_rst_n, rf_we || mem_we, r_state == ST_IDLE, "late write")

    // An instruction is never under way while the core is halted.
    `LC3_ASSERT_NEVER(a_no_exec_halted, i_clk, i_rst_n, r_halt && r_state != ST_IDLE, "halted busy")

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Self-checking testbench of the LC-3 execute block, driven by directed and random programs.
`default_nettype none

module tb_top;
    import lc3_pkg::*;

    // The command code that the block does not know; it must report the state unchanged.
    localparam logic [1:0] CMD_NONE = 2'd3;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int MAX_REPORTS = 50;

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      i_in_valid = 1'b0;
    logic      o_in_ready;
    t_in_item  i_in = '0;
    logic      o_out_valid;
    logic      i_out_ready = 1'b0;
    t_out_item o_out;
    logic      i_cfg_valid = 1'b0;
    logic      o_cfg_ready;
    logic [15:0] i_cfg_data = 16'h0000;

    lc3_instruction_execute dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Shadow copy of the core: memory image with a loaded flag per word, registers and flags.
    logic [15:0] mem_img [0:65535];
    bit          mem_set [0:65535];
    logic [15:0] gpr [0:7];
    logic [15:0] pc_q = 16'h0000;
    logic [1:0]  cc_q = CC_ZERO;
    bit          halt_q = 1'b0;
    logic [15:0] start_pc_q = 16'h3000;

    t_in_item  stim_q [$];
    t_out_item pending_status [$];
    t_out_item want;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_left = 0;
    int cycle_count = 0;
    int mismatches = 0;
    int items_sent = 0;
    int items_live = 0;
    int results_seen = 0;
    int chars_seen = 0;
    int halted_seen = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int k = 0; k < 8; k++) gpr[k] = 16'h0000;
        for (int k = 0; k < 65536; k++) mem_set[k] = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shadow core
    // ------------------------------------------------------------------
    function automatic void store_word(logic [15:0] a, logic [15:0] v);
        mem_img[a] = v;
        mem_set[a] = 1'b1;
    endfunction

    function automatic void set_reg(logic [2:0] r, logic [15:0] v);
        gpr[r] = v;
        if (v == 16'h0000) cc_q = CC_ZERO;
        else if (v[15]) cc_q = CC_NEG;
        else cc_q = CC_POS;
    endfunction

    // Applies one input beat to the shadow core and gives the status beat it must produce.
    function automatic t_out_item lc3_step(t_in_item it);
        t_out_item   r;
        logic [15:0] ir, npc, opb, ea, tgt, off9, off6, off11;
        logic [2:0]  dr, sr;
        r = '0;
        case (it.cmd)
            CMD_WRITE: store_word(it.addr, it.data);
            CMD_START: begin
                pc_q = start_pc_q;
                for (int k = 0; k < 8; k++) gpr[k] = 16'h0000;
                cc_q = CC_ZERO;
                halt_q = 1'b0;
            end
            CMD_EXEC: if (!halt_q) begin
                ir = mem_img[pc_q];
                pc_q = pc_q + 16'd1;
                npc = pc_q;
                dr = ir[11:9];
                sr = ir[8:6];
                opb = ir[5] ? {{11{ir[4]}}, ir[4:0]} : gpr[ir[2:0]];
                off9 = {{7{ir[8]}}, ir[8:0]};
                off6 = {{10{ir[5]}}, ir[5:0]};
                off11 = {{5{ir[10]}}, ir[10:0]};
                case (ir[15:12])
                    OP_ADD: set_reg(dr, gpr[sr] + opb);
                    OP_AND: set_reg(dr, gpr[sr] & opb);
                    OP_NOT: set_reg(dr, ~gpr[sr]);
                    OP_BR: begin
                        // A branch with none of n, z and p set is never taken.
                        if ((ir[11] && cc_q == CC_NEG) || (ir[10] && cc_q == CC_ZERO) ||
                            (ir[9] && cc_q == CC_POS))
                            pc_q = npc + off9;
                    end
                    OP_JMP: pc_q = gpr[sr];
                    OP_JSR: begin
                        // The base register is read before R7 takes the return address.
                        tgt = ir[11] ? npc + off11 : gpr[sr];
                        gpr[7] = npc;
                        pc_q = tgt;
                    end
                    OP_LD: begin
                        ea = npc + off9;
                        set_reg(dr, mem_img[ea]);
                    end
                    OP_LDI: begin
                        ea = npc + off9;
                        ea = mem_img[ea];
                        set_reg(dr, mem_img[ea]);
                    end
                    OP_LDR: begin
                        ea = gpr[sr] + off6;
                        set_reg(dr, mem_img[ea]);
                    end
                    OP_LEA: set_reg(dr, npc + off9);
                    OP_ST: begin
                        ea = npc + off9;
                        store_word(ea, gpr[dr]);
                    end
                    OP_STI: begin
                        ea = npc + off9;
                        ea = mem_img[ea];
                        store_word(ea, gpr[dr]);
                    end
                    OP_STR: begin
                        ea = gpr[sr] + off6;
                        store_word(ea, gpr[dr]);
                    end
                    OP_TRAP: begin
                        case (ir[7:0])
                            VEC_GETC: gpr[0] = {8'h00, it.key_char};
                            VEC_OUT: begin
                                r.char_out = gpr[0][7:0];
                                r.char_valid = 1'b1;
                            end
                            VEC_IN: begin
                                gpr[0] = {8'h00, it.key_char};
                                r.char_out = it.key_char;
                                r.char_valid = 1'b1;
                            end
                            VEC_HALT: halt_q = 1'b1;
                            default: ;
                        endcase
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
        r.pc_now = pc_q;
        r.cond_code = cc_q;
        r.halted = halt_q;
        return r;
    endfunction

    // Finds the first word that the next execute beat would read while it was never loaded.
    function automatic bit find_unloaded(output logic [15:0] a);
        logic [15:0] ir, npc, ea;
        a = 16'h0000;
        if (halt_q) return 1'b0;
        if (!mem_set[pc_q]) begin
            a = pc_q;
            return 1'b1;
        end
        ir = mem_img[pc_q];
        npc = pc_q + 16'd1;
        case (ir[15:12])
            OP_LD, OP_LDI, OP_STI: begin
                ea = npc + {{7{ir[8]}}, ir[8:0]};
                if (!mem_set[ea]) begin
                    a = ea;
                    return 1'b1;
                end
                if (ir[15:12] == OP_LDI) begin
                    ea = mem_img[ea];
                    if (!mem_set[ea]) begin
                        a = ea;
                        return 1'b1;
                    end
                end
            end
            OP_LDR: begin
                ea = gpr[ir[8:6]] + {{10{ir[5]}}, ir[5:0]};
                if (!mem_set[ea]) begin
                    a = ea;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_in_item mk_item(logic [1:0] c, logic [15:0] a, logic [15:0] d,
                                         logic [7:0] k);
        t_in_item it;
        it.cmd = c;
        it.addr = a;
        it.data = d;
        it.key_char = k;
        return it;
    endfunction

    function automatic logic [15:0] rnd16();
        return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [7:0] rnd8();
        return 8'($urandom_range(0, 255));
    endfunction

    // Any opcode, with trap vectors steered towards the ones the core implements.
    function automatic logic [15:0] rand_instr();
        logic [15:0] w;
        int          pick;
        w = rnd16();
        if (w[15:12] == OP_TRAP) begin
            pick = $urandom_range(0, 9);
            if (pick < 3) w[7:0] = VEC_OUT;
            else if (pick < 5) w[7:0] = VEC_GETC;
            else if (pick < 7) w[7:0] = VEC_IN;
            else if (pick == 7) w[7:0] = VEC_HALT;
        end
        return w;
    endfunction

    // Predicts the beat, queues it for the driver and keeps the queue short.
    task automatic push_item(input t_in_item it);
        bit ignored;
        ignored = (it.cmd == CMD_NONE) || (it.cmd == CMD_EXEC && halt_q);
        pending_status.push_back(lc3_step(it));
        stim_q.push_back(it);
        items_sent++;
        if (!ignored) items_live++;
        while (stim_q.size() >= 3) @(posedge i_clk);
    endtask

    // Loads every word the next instruction will read, then executes it.
    task automatic exec_loaded(input logic [7:0] key);
        logic [15:0] a;
        while (find_unloaded(a)) push_item(mk_item(CMD_WRITE, a, rand_instr(), rnd8()));
        push_item(mk_item(CMD_EXEC, rnd16(), rnd16(), key));
    endtask

    // Places a chosen instruction at the current program counter and executes it.
    task automatic exec_word(input logic [15:0] ir, input logic [7:0] key);
        push_item(mk_item(CMD_WRITE, pc_q, ir, rnd8()));
        exec_loaded(key);
    endtask

    task automatic wait_drained();
        while (stim_q.size() != 0 || pending_status.size() != 0) @(posedge i_clk);
    endtask

    // Writes start_pc once the core has gone quiet.
    task automatic write_start_pc(input logic [15:0] v);
        wait_drained();
        repeat (8) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        start_pc_q = v;
    endtask

    // Random programs: mostly instructions run with their operands loaded, the rest noise.
    task automatic random_traffic(input int n);
        int target;
        int roll;
        target = items_live + n;
        while (items_live < target) begin
            roll = $urandom_range(0, 99);
            if (halt_q) begin
                if (roll < 60) push_item(mk_item(CMD_START, rnd16(), rnd16(), rnd8()));
                else if (roll < 80) push_item(mk_item(CMD_EXEC, rnd16(), rnd16(), rnd8()));
                else push_item(mk_item(CMD_WRITE, rnd16(), rnd16(), rnd8()));
            end else if (roll < 4) begin
                push_item(mk_item(CMD_WRITE, rnd16(), rnd16(), rnd8()));
            end else if (roll < 6) begin
                push_item(mk_item(CMD_START, rnd16(), rnd16(), rnd8()));
            end else if (roll < 8) begin
                push_item(mk_item(CMD_NONE, rnd16(), rnd16(), rnd8()));
            end else if (roll < 30 || !mem_set[pc_q]) begin
                // Fresh code keeps tight loops from repeating the same few words.
                exec_word(rand_instr(), rnd8());
            end else begin
                exec_loaded(rnd8());
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_after_reset();
        push_item(mk_item(CMD_WRITE, 16'hFFFF, 16'hFFFF, 8'hFF));
        push_item(mk_item(CMD_WRITE, 16'h0000, 16'h0000, 8'h00));
        push_item(mk_item(CMD_NONE, 16'hFFFF, 16'hFFFF, 8'hFF));
        // Execute before any start runs from address zero: a branch with no condition bits.
        push_item(mk_item(CMD_EXEC, 16'h0000, 16'h0000, 8'h00));
        push_item(mk_item(CMD_START, 16'h0000, 16'hFFFF, 8'h00));
    endtask

    task automatic test_directed_program();
        exec_word(16'h1230, 8'h00);          // ADD R1, R0, #-16
        exec_word(16'h96BF, 8'h00);          // NOT R3, R2
        exec_word(16'h0005, 8'h00);          // BR with no condition bits
        exec_word(16'hE9FF, 8'h00);          // LEA R4, #-1 sets the condition code
        exec_word(16'h4801, 8'h00);          // JSR +1
        exec_word(16'h41C0, 8'h00);          // JSRR R7 reads R7 before it is replaced
        exec_word({OP_TRAP, 4'h0, VEC_GETC}, 8'hA5);
        exec_word({OP_TRAP, 4'h0, VEC_OUT}, 8'h00);
        exec_word({OP_TRAP, 4'h0, VEC_IN}, 8'h5A);
        exec_word({OP_TRAP, 4'h0, VEC_HALT}, 8'h00);
        // Once halted an execute beat changes nothing.
        push_item(mk_item(CMD_EXEC, 16'hFFFF, 16'hFFFF, 8'hFF));
    endtask

    task automatic test_random_slow_drain();
        send_idle_pct = 21;
        recv_idle_pct = 75;
        write_start_pc(16'hFFFF);
        push_item(mk_item(CMD_START, rnd16(), rnd16(), rnd8()));
        random_traffic(630);
    endtask

    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_req = 300;
        random_traffic(40);
        // The sender stops here until every status beat has come back.
        wait_drained();
    endtask

    task automatic test_random_slow_source();
        send_idle_pct = 75;
        recv_idle_pct = 21;
        write_start_pc(16'h0000);
        push_item(mk_item(CMD_START, rnd16(), rnd16(), rnd8()));
        random_traffic(630);
    endtask

    task automatic test_random_full_rate();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_start_pc(rnd16());
        push_item(mk_item(CMD_START, rnd16(), rnd16(), rnd8()));
        random_traffic(600);
    endtask

    // ------------------------------------------------------------------
    // Driver, receiver and checker processes
    // ------------------------------------------------------------------
    // Input driver: holds a beat until it is taken, otherwise offers the next one or idles.
    always @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) void'(stim_q.pop_front());
        if (!(i_in_valid && !o_in_ready)) begin
            if (i_rst_n && stim_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                i_in_valid <= 1'b1;
                i_in <= stim_q[0];
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Result receiver: random stalls, or a long hold-off counted down here.
    always @(posedge i_clk) begin
        if (hold_req != 0) begin
            hold_left = hold_req;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Status checker: every beat taken is compared with the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_status.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: status beat with nothing pending: pc %h cc %0d ch %h/%b halt %b",
                             $time, o_out.pc_now, o_out.cond_code, o_out.char_out,
                             o_out.char_valid, o_out.halted);
            end else begin
                want = pending_status.pop_front();
                results_seen++;
                if (o_out.char_valid) chars_seen++;
                if (o_out.halted) halted_seen++;
                if (o_out !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS) begin
                        $display("%0t: status mismatch: expected pc %h cc %0d ch %h/%b halt %b",
                                 $time, want.pc_now, want.cond_code, want.char_out,
                                 want.char_valid, want.halted);
                        $display("%0t: status mismatch: actual   pc %h cc %0d ch %h/%b halt %b",
                                 $time, o_out.pc_now, o_out.cond_code, o_out.char_out,
                                 o_out.char_valid, o_out.halted);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d status beats outstanding", $time,
                     pending_status.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_after_reset();
        test_directed_program();
        test_random_slow_drain();
        test_random_slow_source();
        test_random_full_rate();
        test_backpressure();
        wait_drained();
        repeat (20) @(posedge i_clk);
        mismatches += pending_status.size();
        $display("Covered %0d beats (%0d effective), %0d status beats checked,", items_sent,
                 items_live, results_seen);
        $display("%0d characters, %0d halted reports, start_pc at both extremes, one hold-off.",
                 chars_seen, halted_seen);
        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire
